// File: hdl/mnes_pkg.sv
// Shared types, constants and the velocity scaling function for the note event scheduler.
package mnes_pkg;

   typedef enum logic [2:0] {
      OP_LOAD   = 3'd0,
      OP_SET    = 3'd1,
      OP_TICK   = 3'd2,
      OP_REWIND = 3'd3,
      OP_SEEK   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_NOTE  = 2'd0,
      KIND_AOFF  = 2'd1,
      KIND_EMPTY = 2'd2
   } kind_type;

   localparam int CHANNELS  = 16;
   localparam int EV_WIDTH  = 50;  // pos 32, chan 4, note 7, vel 7
   localparam int VEL_MAX   = 127;

   // Scale a note-on velocity by a Q1.8 gain; zero stays zero.
   function automatic logic [6:0] scale_velocity(input logic [6:0] vel,
                                                 input logic [8:0] gain);
      logic [15:0] prod;
      logic [7:0]  shifted;
      begin
         prod    = {9'd0, vel} * {7'd0, gain};
         shifted = prod[15:8];
         if (vel == 7'd0)
            scale_velocity = 7'd0;
         else if (shifted == 8'd0)
            scale_velocity = 7'd1;
         else if (shifted > 8'(VEL_MAX))
            scale_velocity = 7'(VEL_MAX);
         else
            scale_velocity = shifted[6:0];
      end
   endfunction

endpackage

// File: hdl/mnes_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module mnes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

// File: hdl/multitrack_note_event_scheduler_top.sv
// Top level of the multitrack note event scheduler.
//
// Channels: operations enter on the req_ stream (one transaction per
// operation); results leave on the rsp_ stream. Only a tick yields results:
// first one all-notes-off per flagged channel (lowest first), then the note
// events of unmuted tracks whose position lies in the window
// [frame_pos, frame_pos + chunk_frames), tracks in ascending order. At most
// MAX_TICK_RESULTS results per tick; rsp_tlast marks the final one and the
// overflow bit on it reports events dropped by the cap. A tick with nothing
// to send gives a single empty marker.
// Load, set, rewind and unknown operations finish in the idle state. A tick
// runs the all-notes-off scan over every channel, then the track steps, a
// read and compare per event with an emit step for each sent one, and a
// wrap-up. Seek does a binary search per present track. Input is accepted
// only while idle.
// Track state lives in flip-flops; events in one synchronous RAM whose reset
// contents are undefined. Reset sets all track state at once (gain to unity), no sweep.
// Each result waits in a staging register until the next one is made or the
// tick ends, so tlast and overflow land on the final one. A stalled receiver
// holds the output register, and a full staging register then stalls the walk.
module multitrack_note_event_scheduler_top
   import mnes_pkg::*;
#(
   parameter int TRACKS = 16,
   parameter int EVENTS_PER_TRACK = 256,
   parameter int MAX_TICK_RESULTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[2:0] track[6:3] slot[14:7] frame_pos[46:15] chunk_frames[62:47]
   // channel[66:63] note[73:67] velocity[80:74] muted[81] volume[90:82]
   // event_count[99:91], zero filled to 104
   input  logic [103:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // kind[1:0] out_channel[5:2] out_note[12:6] out_velocity[19:13]
   // overflow[20], zero filled to 24
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int SW = $clog2(EVENTS_PER_TRACK);
   localparam int CW = SW + 1;
   localparam int AW = TW + SW;
   localparam int NW = $clog2(MAX_TICK_RESULTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_AOFF, S_TRK, S_RD, S_CMP, S_EMIT, S_DONE, S_SK_TRK, S_SK_RD,
      S_SK_CMP, S_FIN
   } state_type;

   // request fields
   logic [2:0]  f_op;
   logic [3:0]  f_track, f_chan;
   logic [7:0]  f_slot;
   logic [31:0] f_pos;
   logic [15:0] f_chunk;
   logic [6:0]  f_note, f_vel;
   logic        f_mute;
   logic [8:0]  f_vol, f_cnt;
   logic [TW-1:0] f_trk;
   assign f_op    = req_tdata[2:0];
   assign f_track = req_tdata[6:3];
   assign f_slot  = req_tdata[14:7];
   assign f_pos   = req_tdata[46:15];
   assign f_chunk = req_tdata[62:47];
   assign f_chan  = req_tdata[66:63];
   assign f_note  = req_tdata[73:67];
   assign f_vel   = req_tdata[80:74];
   assign f_mute  = req_tdata[81];
   assign f_vol   = req_tdata[90:82];
   assign f_cnt   = req_tdata[99:91];
   assign f_trk   = TW'(f_track);

   state_type        state_ff;
   logic [CW-1:0]    cursor_ff [TRACKS];
   logic [CW-1:0]    count_ff  [TRACKS];
   logic [TRACKS-1:0] muted_ff, present_ff;
   logic [8:0]       gain_ff   [TRACKS];
   logic [15:0]      silence_ff;
   logic [31:0]      start_ff;
   logic [32:0]      end_ff;
   logic [TW:0]      trk_ff;
   logic [4:0]       ch_ff;
   logic [CW-1:0]    idx_ff, lo_ff, hi_ff;
   logic [NW-1:0]    n_ff;
   logic             ovf_ff;
   logic             rsp_valid_ff, rsp_last_ff;
   logic [23:0]      rsp_data_ff;
   logic             pend_valid_ff;
   logic [23:0]      pend_data_ff;

   // event memory
   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [EV_WIDTH-1:0] wr_data, rd_data;
   logic [CW-1:0]   mid;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign wr_en   = (state_ff == S_IDLE) && req_tvalid && f_op == OP_LOAD &&
                    int'(f_track) < TRACKS && int'(f_slot) < EVENTS_PER_TRACK;
   assign wr_addr = {f_trk, SW'(f_slot)};
   assign wr_data = {f_vel, f_note, f_chan, f_pos};
   assign rd_addr = (state_ff == S_SK_RD) ? {trk_ff[TW-1:0], mid[SW-1:0]}
                                          : {trk_ff[TW-1:0], idx_ff[SW-1:0]};

   mnes_ram #(.WIDTH(EV_WIDTH), .DEPTH(1 << AW)) u_events (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [31:0] ev_pos;
   logic [3:0]  ev_chan;
   logic [6:0]  ev_note, ev_vel;
   assign ev_pos  = rd_data[31:0];
   assign ev_chan = rd_data[35:32];
   assign ev_note = rd_data[42:36];
   assign ev_vel  = rd_data[49:43];

   logic out_free;
   logic stage_req, stage_go, out_load;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_valid_ff && rsp_last_ff;

   // A new result can be staged when the staging register is empty or its
   // content can move on to the output register this cycle.
   assign stage_req = (state_ff == S_AOFF && ch_ff != 5'(CHANNELS) &&
                       silence_ff[ch_ff[3:0]]) ||
                      (state_ff == S_EMIT && n_ff != NW'(MAX_TICK_RESULTS));
   assign stage_go  = stage_req && (!pend_valid_ff || out_free);
   assign out_load  = (stage_req && pend_valid_ff && out_free) ||
                      (state_ff == S_DONE && out_free);

   logic [TW-1:0] t;
   assign t = trk_ff[TW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         muted_ff      <= '0;
         present_ff    <= '0;
         silence_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         for (int i = 0; i < TRACKS; i++) begin
            cursor_ff[i] <= '0;
            count_ff[i]  <= '0;
            gain_ff[i]   <= 9'd256;
         end
      end else begin
         rsp_valid_ff <= out_load || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  case (f_op)
                     OP_SET: begin
                        if (int'(f_track) < TRACKS) begin
                           if (f_mute && present_ff[f_trk] && !muted_ff[f_trk])
                              silence_ff[f_chan] <= 1'b1;
                           present_ff[f_trk] <= 1'b1;
                           muted_ff[f_trk]   <= f_mute;
                           gain_ff[f_trk]    <= f_vol;
                           count_ff[f_trk]   <=
                              (int'(f_cnt) > EVENTS_PER_TRACK) ? CW'(EVENTS_PER_TRACK)
                                                              : CW'(f_cnt);
                           for (int i = 0; i < TRACKS; i++) cursor_ff[i] <= '0;
                        end
                     end
                     OP_REWIND: for (int i = 0; i < TRACKS; i++) cursor_ff[i] <= '0;
                     OP_TICK: begin
                        start_ff <= f_pos;
                        end_ff   <= {1'b0, f_pos} + {17'd0, f_chunk};
                        ch_ff    <= '0;
                        n_ff     <= '0;
                        ovf_ff   <= 1'b0;
                        state_ff <= S_AOFF;
                     end
                     OP_SEEK: begin
                        start_ff <= f_pos;
                        trk_ff   <= '0;
                        state_ff <= S_SK_TRK;
                     end
                     default: ;
                  endcase
               end
            end
            // flush all-notes-off, one channel per cycle while staging is not stalled
            S_AOFF: begin
               if (ch_ff == 5'(CHANNELS)) begin
                  silence_ff <= '0;
                  trk_ff     <= '0;
                  state_ff   <= S_TRK;
               end else if (!silence_ff[ch_ff[3:0]]) begin
                  ch_ff <= ch_ff + 5'd1;
               end else if (stage_go) begin
                  if (pend_valid_ff) begin
                     rsp_last_ff <= 1'b0;
                     rsp_data_ff <= pend_data_ff;
                  end
                  pend_valid_ff <= 1'b1;
                  pend_data_ff  <= {3'd0, 1'b0, 7'd0, 7'd0, ch_ff[3:0], KIND_AOFF};
                  n_ff          <= n_ff + NW'(1);
                  ch_ff         <= ch_ff + 5'd1;
               end
            end
            S_TRK: begin
               if (trk_ff == (TW+1)'(TRACKS)) begin
                  state_ff <= S_DONE;
               end else if (!present_ff[t] || muted_ff[t] || count_ff[t] == '0 ||
                            cursor_ff[t] >= count_ff[t]) begin
                  trk_ff <= trk_ff + 1'b1;
               end else begin
                  idx_ff   <= cursor_ff[t];
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_CMP;
            S_CMP: begin
               if ({1'b0, ev_pos} >= end_ff) begin
                  cursor_ff[t] <= idx_ff;
                  trk_ff       <= trk_ff + 1'b1;
                  state_ff     <= S_TRK;
               end else if (ev_pos >= start_ff) begin
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_EMIT: begin
               if (n_ff == NW'(MAX_TICK_RESULTS)) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= S_FIN;
               end else if (stage_go) begin
                  if (pend_valid_ff) begin
                     rsp_last_ff <= 1'b0;
                     rsp_data_ff <= pend_data_ff;
                  end
                  pend_valid_ff <= 1'b1;
                  pend_data_ff  <= {3'd0, 1'b0, scale_velocity(ev_vel, gain_ff[t]),
                                    ev_note, ev_chan, KIND_NOTE};
                  n_ff          <= n_ff + NW'(1);
                  state_ff      <= S_FIN;
               end
            end
            // advance to the next event of this track, or to the next track after its last
            S_FIN: begin
               if (idx_ff + 1'b1 >= count_ff[t]) begin
                  cursor_ff[t] <= idx_ff + 1'b1;
                  trk_ff       <= trk_ff + 1'b1;
                  state_ff     <= S_TRK;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            // release the staged result as the final one, or the empty marker
            S_DONE: begin
               if (out_free) begin
                  rsp_last_ff <= 1'b1;
                  if (n_ff == '0) begin
                     rsp_data_ff <= {3'd0, 1'b0, 7'd0, 7'd0, 4'd0, KIND_EMPTY};
                  end else begin
                     rsp_data_ff   <= {pend_data_ff[23:21], ovf_ff, pend_data_ff[19:0]};
                     pend_valid_ff <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_SK_TRK: begin
               if (trk_ff == (TW+1)'(TRACKS)) begin
                  state_ff <= S_IDLE;
               end else if (!present_ff[t]) begin
                  trk_ff <= trk_ff + 1'b1;
               end else begin
                  lo_ff    <= '0;
                  hi_ff    <= count_ff[t];
                  state_ff <= S_SK_RD;
               end
            end
            S_SK_RD: begin
               if (lo_ff >= hi_ff) begin
                  cursor_ff[t] <= lo_ff;
                  trk_ff       <= trk_ff + 1'b1;
                  state_ff     <= S_SK_TRK;
               end else begin
                  idx_ff   <= mid;
                  state_ff <= S_SK_CMP;
               end
            end
            S_SK_CMP: begin
               if (ev_pos < start_ff) lo_ff <= idx_ff + 1'b1;
               else                   hi_ff <= idx_ff;
               state_ff <= S_SK_RD;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // A result waiting on a stalled receiver holds its data and last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Overflow is only reported on the last result of a tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20] |-> rsp_tlast)
      else $error("overflow on a non-final result");

   // No operation is accepted while a tick or seek walk is in progress.
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("ready while busy");

endmodule
